>>> src/gwdte_pkg.sv
// Shared types, constants and key lookups for the gRPC-Web deframer.
`timescale 1ns / 1ps
`default_nettype none
package gwdte_pkg;

  localparam logic [30:0] STATUS_MAX      = 31'h7FFF_FFFF;
  localparam logic [3:0]  STATUS_KEY_LEN  = 4'd12;
  localparam logic [3:0]  MESSAGE_KEY_LEN = 4'd13;
  localparam logic [7:0]  CHAR_ZERO       = 8'h30;
  localparam logic [7:0]  CHAR_NINE       = 8'h39;
  localparam logic [7:0]  CHAR_CR         = 8'h0D;
  localparam logic [7:0]  CHAR_LF         = 8'h0A;
  localparam int unsigned FLAG_COMPRESSED = 0;
  localparam int unsigned FLAG_TRAILERS   = 7;

  // Frame parse position: flag byte, four length bytes, then the body.
  typedef enum logic [5:0] {
    HDR_FLAG = 6'b000001,
    HDR_LEN0 = 6'b000010,
    HDR_LEN1 = 6'b000100,
    HDR_LEN2 = 6'b001000,
    HDR_LEN3 = 6'b010000,
    HDR_BODY = 6'b100000
  } hdr_state_t;

  typedef enum logic [3:0] {
    ST_SEARCH      = 4'b0001,
    ST_FIRST_DIGIT = 4'b0010,
    ST_DIGITS      = 4'b0100,
    ST_NONE        = 4'b1000
  } status_state_t;

  typedef enum logic [2:0] {
    MSG_SEARCH = 3'b001,
    MSG_VALUE  = 3'b010,
    MSG_ENDED  = 3'b100
  } msg_state_t;

  typedef struct packed {
    logic [7:0]  body_byte;
    logic        has_data;
    logic [7:0]  frame_flags;
    logic        compressed;
    logic        is_trailers;
    logic        last_of_frame;
    logic [31:0] body_length;
    logic        status_found;
    logic [30:0] status_value;
    logic        message_found;
    logic [31:0] message_offset;
    logic [31:0] message_length;
  } result_t;

  typedef struct packed {
    logic [3:0] idx;
    logic       hit;
  } key_match_t;

  function automatic logic [7:0] status_key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "g";
      4'd1:    c = "r";
      4'd2:    c = "p";
      4'd3:    c = "c";
      4'd4:    c = "-";
      4'd5:    c = "s";
      4'd6:    c = "t";
      4'd7:    c = "a";
      4'd8:    c = "t";
      4'd9:    c = "u";
      4'd10:   c = "s";
      4'd11:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] message_key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "g";
      4'd1:    c = "r";
      4'd2:    c = "p";
      4'd3:    c = "c";
      4'd4:    c = "-";
      4'd5:    c = "m";
      4'd6:    c = "e";
      4'd7:    c = "s";
      4'd8:    c = "s";
      4'd9:    c = "a";
      4'd10:   c = "g";
      4'd11:   c = "e";
      4'd12:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // One step of a key matcher that only starts at the beginning of a line.
  function automatic key_match_t key_advance(
    input logic [3:0] idx,
    input logic [3:0] key_len,
    input logic [7:0] char_at_idx,
    input logic [7:0] first_char,
    input logic       line_start,
    input logic [7:0] b
  );
    key_match_t m;
    m.idx = idx;
    m.hit = 1'b0;
    if (idx != 4'd0) begin
      if ((idx < key_len) && (b == char_at_idx)) begin
        if ((idx + 4'd1) == key_len) begin
          m.idx = 4'd0;
          m.hit = 1'b1;
        end else begin
          m.idx = idx + 4'd1;
        end
      end else begin
        m.idx = 4'd0;
      end
    end else if (line_start && (b == first_char)) begin
      m.idx = 4'd1;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

>>> src/grpc_web_deframer_trailer_extract_unit.sv
// gRPC-Web frame deframer with grpc-status / grpc-message trailer extraction.
// Takes one stream byte per clock and never stalls on its own: the five header
// bytes of a frame (flag, big-endian 32-bit length) give no transaction, each
// body byte gives one transaction in the cycle after it is taken, and an empty
// body gives a single marker transaction with has_data low. All per-byte work
// (header shift, key matchers, status multiply-by-ten with saturation, message
// counters) sits between the input and one output register, so the rate is one
// byte per cycle while the consumer does not stall. in_stall rises only while the
// output register holds a transaction that the consumer is stalling. Status and
// message results are reported on the last transaction of a trailers frame.
`timescale 1ns / 1ps
`default_nettype none
module grpc_web_deframer_trailer_extract_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_stream_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_body_byte,
  output logic             out_has_data,
  output logic [7:0]       out_frame_flags,
  output logic             out_compressed,
  output logic             out_is_trailers,
  output logic             out_last_of_frame,
  output logic [31:0]      out_body_length,
  output logic             out_status_found,
  output logic [30:0]      out_status_value,
  output logic             out_message_found,
  output logic [31:0]      out_message_offset,
  output logic [31:0]      out_message_length
);
  import gwdte_pkg::*;

  hdr_state_t    hdr_r, hdr_nxt;
  status_state_t st_r, st_nxt;
  msg_state_t    msg_r, msg_nxt;
  logic [7:0]    flag_r, flag_nxt;
  logic [31:0]   len_r, len_nxt;
  logic [31:0]   pos_r, pos_nxt;
  logic          line_start_r, line_start_nxt;
  logic [3:0]    st_idx_r, st_idx_nxt;
  logic [3:0]    msg_idx_r, msg_idx_nxt;
  logic [30:0]   acc_r, acc_nxt;
  logic [31:0]   msg_start_r, msg_start_nxt;
  logic [31:0]   msg_count_r, msg_count_nxt;
  result_t       res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          in_acc;
  logic          load;
  logic          is_digit;
  logic          is_eol;
  logic [31:0]   len_shift;
  logic [34:0]   mul10;
  logic [30:0]   acc_step;
  logic          body_last;
  key_match_t    st_m;
  key_match_t    msg_m;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign is_digit  = (in_stream_byte >= CHAR_ZERO) && (in_stream_byte <= CHAR_NINE);
  assign is_eol    = (in_stream_byte == CHAR_CR) || (in_stream_byte == CHAR_LF);
  assign len_shift = {len_r[23:0], in_stream_byte};
  assign body_last = (pos_r == (len_r - 32'd1));

  // acc * 10 + digit, saturated to the 31-bit maximum
  assign mul10    = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1)
                  + {31'd0, in_stream_byte[3:0]};
  assign acc_step = (|mul10[34:31]) ? STATUS_MAX : mul10[30:0];

  assign st_m  = key_advance(st_idx_r, STATUS_KEY_LEN, status_key_char(st_idx_r),
                             status_key_char(4'd0), line_start_r, in_stream_byte);
  assign msg_m = key_advance(msg_idx_r, MESSAGE_KEY_LEN, message_key_char(msg_idx_r),
                             message_key_char(4'd0), line_start_r, in_stream_byte);

  always_comb begin
    hdr_nxt        = hdr_r;
    st_nxt         = st_r;
    msg_nxt        = msg_r;
    flag_nxt       = flag_r;
    len_nxt        = len_r;
    pos_nxt        = pos_r;
    line_start_nxt = line_start_r;
    st_idx_nxt     = st_idx_r;
    msg_idx_nxt    = msg_idx_r;
    acc_nxt        = acc_r;
    msg_start_nxt  = msg_start_r;
    msg_count_nxt  = msg_count_r;
    load           = 1'b0;
    res_nxt        = res_r;

    if (in_acc) begin
      case (hdr_r)
        HDR_FLAG: begin
          flag_nxt       = in_stream_byte;
          len_nxt        = 32'd0;
          pos_nxt        = 32'd0;
          line_start_nxt = 1'b1;
          st_idx_nxt     = 4'd0;
          msg_idx_nxt    = 4'd0;
          st_nxt         = ST_SEARCH;
          acc_nxt        = 31'd0;
          msg_nxt        = MSG_SEARCH;
          msg_start_nxt  = 32'd0;
          msg_count_nxt  = 32'd0;
          hdr_nxt        = HDR_LEN0;
        end
        HDR_LEN0: begin
          len_nxt = len_shift;
          hdr_nxt = HDR_LEN1;
        end
        HDR_LEN1: begin
          len_nxt = len_shift;
          hdr_nxt = HDR_LEN2;
        end
        HDR_LEN2: begin
          len_nxt = len_shift;
          hdr_nxt = HDR_LEN3;
        end
        HDR_LEN3: begin
          len_nxt = len_shift;
          if (len_shift == 32'd0) begin
            hdr_nxt = HDR_FLAG;
            load    = 1'b1;
          end else begin
            hdr_nxt = HDR_BODY;
          end
        end
        HDR_BODY: begin
          load = 1'b1;
          if (flag_r[FLAG_TRAILERS]) begin
            case (st_r)
              ST_SEARCH: begin
                st_idx_nxt = st_m.idx;
                if (st_m.hit) begin
                  st_nxt = ST_FIRST_DIGIT;
                end
              end
              ST_FIRST_DIGIT: begin
                if (is_digit) begin
                  acc_nxt    = {27'd0, in_stream_byte[3:0]};
                  st_idx_nxt = 4'd0;
                  st_nxt     = ST_DIGITS;
                end else begin
                  st_nxt = ST_NONE;
                end
              end
              ST_DIGITS: begin
                // index register doubles as the end-of-digits mark here
                if (st_idx_r == 4'd0) begin
                  if (is_digit) begin
                    acc_nxt = acc_step;
                  end else begin
                    st_idx_nxt = 4'd1;
                  end
                end
              end
              default: begin
                st_nxt = st_r;
              end
            endcase

            case (msg_r)
              MSG_SEARCH: begin
                msg_idx_nxt = msg_m.idx;
                if (msg_m.hit) begin
                  msg_nxt       = MSG_VALUE;
                  msg_start_nxt = pos_r + 32'd1;
                  msg_count_nxt = 32'd0;
                end
              end
              MSG_VALUE: begin
                if (is_eol) begin
                  msg_nxt = MSG_ENDED;
                end else begin
                  msg_count_nxt = msg_count_r + 32'd1;
                end
              end
              default: begin
                msg_nxt = msg_r;
              end
            endcase

            line_start_nxt = (in_stream_byte == CHAR_LF);
          end

          if (body_last) begin
            hdr_nxt = HDR_FLAG;
          end else begin
            pos_nxt = pos_r + 32'd1;
          end
        end
        default: begin
          hdr_nxt = HDR_FLAG;
        end
      endcase
    end

    if (load) begin
      res_nxt.body_byte      = (hdr_r == HDR_BODY) ? in_stream_byte : 8'd0;
      res_nxt.has_data       = (hdr_r == HDR_BODY);
      res_nxt.frame_flags    = flag_r;
      res_nxt.compressed     = flag_r[FLAG_COMPRESSED];
      res_nxt.is_trailers    = flag_r[FLAG_TRAILERS];
      res_nxt.last_of_frame  = (hdr_r != HDR_BODY) || body_last;
      res_nxt.body_length    = len_nxt;
      res_nxt.status_found   = 1'b0;
      res_nxt.status_value   = 31'd0;
      res_nxt.message_found  = 1'b0;
      res_nxt.message_offset = 32'd0;
      res_nxt.message_length = 32'd0;
      if ((hdr_r == HDR_BODY) && body_last && flag_r[FLAG_TRAILERS]) begin
        if (st_nxt == ST_DIGITS) begin
          res_nxt.status_found = 1'b1;
          res_nxt.status_value = acc_nxt;
        end
        if ((msg_nxt == MSG_VALUE) || (msg_nxt == MSG_ENDED)) begin
          res_nxt.message_found  = 1'b1;
          res_nxt.message_offset = msg_start_nxt;
          res_nxt.message_length = msg_count_nxt;
        end
      end
    end

    // hold while stalled, drop once taken, refill on a new transaction
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r        <= HDR_FLAG;
      st_r         <= ST_SEARCH;
      msg_r        <= MSG_SEARCH;
      flag_r       <= 8'd0;
      len_r        <= 32'd0;
      pos_r        <= 32'd0;
      line_start_r <= 1'b1;
      st_idx_r     <= 4'd0;
      msg_idx_r    <= 4'd0;
      acc_r        <= 31'd0;
      msg_start_r  <= 32'd0;
      msg_count_r  <= 32'd0;
      out_valid_r  <= 1'b0;
    end else begin
      hdr_r        <= hdr_nxt;
      st_r         <= st_nxt;
      msg_r        <= msg_nxt;
      flag_r       <= flag_nxt;
      len_r        <= len_nxt;
      pos_r        <= pos_nxt;
      line_start_r <= line_start_nxt;
      st_idx_r     <= st_idx_nxt;
      msg_idx_r    <= msg_idx_nxt;
      acc_r        <= acc_nxt;
      msg_start_r  <= msg_start_nxt;
      msg_count_r  <= msg_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_body_byte      = res_r.body_byte;
  assign out_has_data       = res_r.has_data;
  assign out_frame_flags    = res_r.frame_flags;
  assign out_compressed     = res_r.compressed;
  assign out_is_trailers    = res_r.is_trailers;
  assign out_last_of_frame  = res_r.last_of_frame;
  assign out_body_length    = res_r.body_length;
  assign out_status_found   = res_r.status_found;
  assign out_status_value   = res_r.status_value;
  assign out_message_found  = res_r.message_found;
  assign out_message_offset = res_r.message_offset;
  assign out_message_length = res_r.message_length;

  // Trailer results appear only on the last transaction of a trailers frame.
  a_found_only_at_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status_found || out_message_found)
      |-> out_last_of_frame && out_is_trailers && out_has_data)
    else $error("trailer result outside last transaction of a trailers frame");

  // An empty-body marker is a zero-length, last, dataless transaction.
  a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_data
      |-> out_last_of_frame && (out_body_length == 32'd0) && (out_body_byte == 8'd0))
    else $error("malformed empty-body marker");

  // Header bytes never produce a transaction.
  a_header_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (hdr_r != HDR_BODY) && (hdr_r != HDR_LEN3) |=> !out_valid || $past(in_stall)
      || !$past(out_stall) == 1'b0)
    else $error("header byte produced a transaction");

  // The flags of a transaction agree with its decoded bits.
  a_flag_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_compressed == out_frame_flags[FLAG_COMPRESSED])
      && (out_is_trailers == out_frame_flags[FLAG_TRAILERS]))
    else $error("decoded flag bits disagree with frame flags");

endmodule
`default_nettype wire
